/* hw/rtl/spq_pkg.sv */
`default_nettype none

package spq_pkg;

    localparam int DEPTH = 8;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 2;
    localparam int OCC_W = 4;

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;  // enqueue that will be stored
        logic deq;  // dequeue that removes the head
    } t_cell_ctl;

endpackage

`default_nettype wire

/* hw/rtl/sorted_priority_queue.sv */
// channel   | direction | strobe / handshake        | payload
// ----------+-----------+---------------------------+------------------------------------------
// request   | in        | start high, busy low      | i_cmd, i_item_data, i_item_priority
// result    | out       | o_valid high for 1 cycle  | o_out_data, o_out_priority, o_status,
//           |           |                           | o_occupancy
//
// one request per cycle, result appears on the cycle after the request edge
// every cell compares and shifts in parallel, so busy never rises
// reset clears the entry count and the result strobe, cell contents stay as they are
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    output logic                     busy,
    input  wire                      i_cmd,
    input  wire signed [DATA_W-1:0]  i_item_data,
    input  wire        [PRIO_W-1:0]  i_item_priority,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_out_data,
    output logic        [PRIO_W-1:0] o_out_priority,
    output logic        [STAT_W-1:0] o_status,
    output logic        [OCC_W-1:0]  o_occupancy
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic [PRIO_W-1:0] r_prio;
    logic [PRIO_W-1:0] n_prio;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [OCC_W-1:0]  r_occ;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;
    t_entry    w_new;
    t_entry    w_zero;
    t_entry    w_entry [DEPTH];
    logic      w_lower [DEPTH];
    logic [CNT_W+OCC_W-1:0] w_count_ext;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_ctl.enq = w_accept && (i_cmd == CMD_ENQUEUE) && !w_full;
    assign w_ctl.deq = w_accept && (i_cmd == CMD_DEQUEUE) && !w_empty;

    assign w_new.data = i_item_data;
    assign w_new.prio = i_item_priority;
    assign w_zero     = '0;

    // chain of cells, slot 0 holds the head of the queue
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_valid      (r_count > CNT_W'(i)),
            .i_new        (w_new),
            .i_left       ((i == 0) ? w_zero : w_entry[(i == 0) ? 0 : i - 1]),
            .i_left_lower ((i == 0) ? 1'b0 : w_lower[(i == 0) ? 0 : i - 1]),
            .i_right      ((i == DEPTH - 1) ? w_zero
                                            : w_entry[(i == DEPTH - 1) ? i : i + 1]),
            .o_entry      (w_entry[i]),
            .o_lower      (w_lower[i])
        );
    end

    // count and result for this request
    always_comb begin
        n_count  = r_count;
        n_data   = '0;
        n_prio   = '0;
        n_status = ST_OK;
        if (i_cmd == CMD_DEQUEUE) begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_data  = w_entry[0].data;
                n_prio  = w_entry[0].prio;
                n_count = r_count - CNT_W'(1);
            end
        end else begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // occupancy reports the low bits of the count
    assign w_count_ext = (CNT_W + OCC_W)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data   <= n_data;
            r_prio   <= n_prio;
            r_status <= n_status;
            r_occ    <= w_count_ext[OCC_W-1:0];
        end
    end

    assign o_valid        = r_valid;
    assign o_out_data     = r_data;
    assign o_out_priority = r_prio;
    assign o_status       = r_status;
    assign o_occupancy    = r_occ;

    // occupancy never passes the number of cells
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // one result for each accepted request, on the next cycle
    a_result_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("missing result strobe");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_valid)
        else $error("result without request");

    // dequeue on an empty queue reports empty and keeps the count
    a_empty_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == CMD_DEQUEUE) && w_empty)
            |=> (o_status == ST_EMPTY) && (r_count == '0))
        else $error("bad empty dequeue result");

    // head is never below its successor
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_entry[0].prio >= w_entry[1].prio))
        else $error("queue head out of order");

endmodule

`default_nettype wire

/* hw/rtl/spq_cell.sv */
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire        i_clk,
    input  t_cell_ctl  i_ctl,
    input  wire        i_valid,
    input  t_entry     i_new,
    input  t_entry     i_left,
    input  wire        i_left_lower,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output logic       o_lower
);

    t_entry r_entry;
    t_entry n_entry;

    // empty slot or strictly lower priority: new entry goes at or before here
    assign o_lower = !i_valid || (r_entry.prio < i_new.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq) begin
            if (i_left_lower) begin
                n_entry = i_left;
            end else if (o_lower) begin
                n_entry = i_new;
            end
        end else if (i_ctl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire
